FILE: rtl/core/complementary_tilt_angle_filter_top_assert.svh
// ----------------------------------------------------------------------------
// Tilt filter assertion macros
// Shorthand for clocked checks of the filter top level, gated by reset.
// ----------------------------------------------------------------------------
`ifndef COMPLEMENTARY_TILT_ANGLE_FILTER_TOP_ASSERT_SVH
`define COMPLEMENTARY_TILT_ANGLE_FILTER_TOP_ASSERT_SVH

// same-cycle implication
`define CTAF_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("tilt filter: same-cycle check failed");

// next-cycle implication
`define CTAF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("tilt filter: next-cycle check failed");

// invariant
`define CTAF_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error("tilt filter: invariant failed");

`endif

FILE: rtl/core/ctaf_pkg.sv
// ----------------------------------------------------------------------------
// Tilt filter package
// Widths, register indexes, CORDIC angle table and the controller command.
// ----------------------------------------------------------------------------
package ctaf_pkg;

    localparam int CORDIC_STEPS        = 16;
    localparam int ANGLE_FRACTION_BITS = 16;

    localparam int TAB_BITS  = 24;
    localparam int TAB_LEN   = 24;
    localparam int TAB_IDX_W = 5;
    localparam int TAB_ENT_W = 30;

    localparam int ACCEL_W = 16;
    localparam int RATE_W  = 24;
    localparam int ALPHA_W = 17;
    localparam int DT_W    = 20;
    localparam int ANGLE_W = ANGLE_FRACTION_BITS + 10;
    localparam int UP      = TAB_BITS - ANGLE_FRACTION_BITS;

    localparam int CORDIC_W = 27;
    localparam int ACC_W    = 35;
    localparam int MUL_A_W  = 24;
    localparam int MUL_B_W  = DT_W + 1;
    localparam int PROD_W   = 46;
    localparam int DIFF_W   = 46;
    localparam int D_SPLIT  = 23;
    localparam int BLEND_W  = 64;
    localparam int BLEND_SH = 16 + UP;
    localparam int RND_W    = BLEND_W - BLEND_SH;
    localparam int ITER_W   = $clog2(CORDIC_STEPS);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    localparam logic [CFG_IDX_W-1:0] REG_BLEND_WEIGHT  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD = CFG_IDX_W'(1);

    localparam logic [ALPHA_W-1:0] ALPHA_ONE   = ALPHA_W'(65536);
    localparam logic [ALPHA_W-1:0] ALPHA_RESET = ALPHA_W'(58982);
    localparam logic [DT_W-1:0]    DT_RESET    = DT_W'(6554);

    localparam logic [ITER_W-1:0] LAST_ITER = ITER_W'(CORDIC_STEPS - 1);

    localparam logic signed [ACC_W-1:0] ACC_HALF_TURN =
        ACC_W'(longint'(180) << TAB_BITS);
    localparam logic signed [ACC_W-1:0] TILT_RND =
        ACC_W'((longint'(1) << UP) >> 1);
    localparam logic signed [BLEND_W-1:0] BLEND_RND =
        BLEND_W'(longint'(1) << (BLEND_SH - 1));
    localparam logic signed [RND_W-1:0] ANGLE_MAX =
        RND_W'((longint'(1) << (ANGLE_W - 1)) - 1);
    localparam logic signed [RND_W-1:0] ANGLE_MIN =
        RND_W'(-(longint'(1) << (ANGLE_W - 1)));

    typedef struct packed {
        logic              load;
        logic              iterate;
        logic [ITER_W-1:0] iter_idx;
        logic              tilt;
        logic              diff;
        logic              mul_lo;
        logic              mul_hi;
        logic              sum;
        logic              round;
        logic              commit;
    } dp_cmd_t;

    // atan(2^-i) in degrees, 24 fraction bits
    function automatic logic [TAB_ENT_W-1:0] atan_entry(input logic [TAB_IDX_W-1:0] idx);
        logic [TAB_ENT_W-1:0] val;
        case (idx)
            5'd0:    val = 30'd754974720;
            5'd1:    val = 30'd445687602;
            5'd2:    val = 30'd235489088;
            5'd3:    val = 30'd119537938;
            5'd4:    val = 30'd60000934;
            5'd5:    val = 30'd30029717;
            5'd6:    val = 30'd15018523;
            5'd7:    val = 30'd7509720;
            5'd8:    val = 30'd3754917;
            5'd9:    val = 30'd1877466;
            5'd10:   val = 30'd938734;
            5'd11:   val = 30'd469367;
            5'd12:   val = 30'd234684;
            5'd13:   val = 30'd117342;
            5'd14:   val = 30'd58671;
            5'd15:   val = 30'd29335;
            5'd16:   val = 30'd14668;
            5'd17:   val = 30'd7334;
            5'd18:   val = 30'd3667;
            5'd19:   val = 30'd1833;
            5'd20:   val = 30'd917;
            5'd21:   val = 30'd458;
            5'd22:   val = 30'd229;
            5'd23:   val = 30'd115;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

FILE: rtl/core/complementary_tilt_angle_filter_top.sv
// ----------------------------------------------------------------------------
// Complementary tilt-angle filter top level
// Steps: input load, CORDIC iterations, then tilt, diff, mul_lo, mul_hi, sum,
// round and commit. A new input is taken only in idle, after the last commit;
// a waiting result holds the commit and with it the next input transfer.
// Reset (aresetn low, synchronous): idle, angle cleared, registers to defaults.
// ----------------------------------------------------------------------------
`include "complementary_tilt_angle_filter_top_assert.svh"

module complementary_tilt_angle_filter_top (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [ctaf_pkg::ACCEL_W-1:0]  s_accel_x,
    input  logic signed [ctaf_pkg::ACCEL_W-1:0]  s_accel_z,
    input  logic signed [ctaf_pkg::RATE_W-1:0]   s_gyro_rate,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [ctaf_pkg::ANGLE_W-1:0]  m_tilt_angle,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [ctaf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ctaf_pkg::CFG_DATA_W-1:0]      cfg_data
);

    ctaf_pkg::dp_cmd_t dp_cmd;
    logic              cfg_wr;
    logic [8:0]        dp_steps;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    assign dp_steps = {dp_cmd.load, dp_cmd.iterate, dp_cmd.tilt, dp_cmd.diff, dp_cmd.mul_lo,
                       dp_cmd.mul_hi, dp_cmd.sum, dp_cmd.round, dp_cmd.commit};

    ctaf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (dp_cmd)
    );

    ctaf_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (dp_cmd),
        .s_accel_x    (s_accel_x),
        .s_accel_z    (s_accel_z),
        .s_gyro_rate  (s_gyro_rate),
        .cfg_wr       (cfg_wr),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .m_tilt_angle (m_tilt_angle)
    );

    `CTAF_ASSERT_NEXT(a_one_in_flight, s_valid && s_ready, !s_ready)
    `CTAF_ASSERT_SAME(a_commit_free, dp_cmd.commit, !m_valid || m_ready)
    `CTAF_ASSERT_ALWAYS(a_single_step, $onehot0(dp_steps))

endmodule

FILE: rtl/core/ctaf_ctrl.sv
// ----------------------------------------------------------------------------
// Tilt filter controller
// Sequences load, CORDIC iterations, blend arithmetic and result hand-off.
// ----------------------------------------------------------------------------
module ctaf_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output ctaf_pkg::dp_cmd_t cmd
);

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_ITER   = 9'b000000010,
        ST_TILT   = 9'b000000100,
        ST_DIFF   = 9'b000001000,
        ST_MUL_LO = 9'b000010000,
        ST_MUL_HI = 9'b000100000,
        ST_SUM    = 9'b001000000,
        ST_ROUND  = 9'b010000000,
        ST_COMMIT = 9'b100000000
    } state_t;

    state_t                        state_reg, state_next;
    logic [ctaf_pkg::ITER_W-1:0]   iter_reg, iter_next;
    logic                          m_valid_reg, m_valid_next;
    logic                          out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        iter_next    = iter_reg;
        cmd          = '0;
        cmd.iter_idx = iter_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    iter_next  = '0;
                    state_next = ST_ITER;
                end
            end
            ST_ITER: begin
                cmd.iterate = 1'b1;
                iter_next   = iter_reg + 1'b1;
                if (iter_reg == ctaf_pkg::LAST_ITER) begin
                    state_next = ST_TILT;
                end
            end
            ST_TILT: begin
                cmd.tilt   = 1'b1;
                state_next = ST_DIFF;
            end
            ST_DIFF: begin
                cmd.diff   = 1'b1;
                state_next = ST_MUL_LO;
            end
            ST_MUL_LO: begin
                cmd.mul_lo = 1'b1;
                state_next = ST_MUL_HI;
            end
            ST_MUL_HI: begin
                cmd.mul_hi = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM: begin
                cmd.sum    = 1'b1;
                state_next = ST_ROUND;
            end
            ST_ROUND: begin
                cmd.round  = 1'b1;
                state_next = ST_COMMIT;
            end
            ST_COMMIT: begin
                // hold until the previous result is taken
                if (out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.commit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            iter_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            iter_reg    <= iter_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

FILE: rtl/core/ctaf_dp.sv
// ----------------------------------------------------------------------------
// Tilt filter datapath
// Vectoring CORDIC, shared multiplier, blend, rounding and saturation.
// ----------------------------------------------------------------------------
module ctaf_dp (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  ctaf_pkg::dp_cmd_t                      cmd,
    input  logic signed [ctaf_pkg::ACCEL_W-1:0]    s_accel_x,
    input  logic signed [ctaf_pkg::ACCEL_W-1:0]    s_accel_z,
    input  logic signed [ctaf_pkg::RATE_W-1:0]     s_gyro_rate,
    input  logic                                   cfg_wr,
    input  logic [ctaf_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [ctaf_pkg::CFG_DATA_W-1:0]        cfg_data,
    output logic signed [ctaf_pkg::ANGLE_W-1:0]    m_tilt_angle
);

    logic signed [ctaf_pkg::CORDIC_W-1:0] x_reg, x_next, z_reg, z_next;
    logic signed [ctaf_pkg::CORDIC_W-1:0] xs, zs, dx, dz;
    logic signed [ctaf_pkg::ACC_W-1:0]    acc_reg, acc_next, step_ang;
    logic                                 zero_reg, zero_next;
    logic signed [ctaf_pkg::RATE_W-1:0]   rate_reg, rate_next;
    logic signed [ctaf_pkg::ANGLE_W-1:0]  tilt_reg, tilt_next;
    logic signed [ctaf_pkg::PROD_W-1:0]   prod_reg, prod_next, mul_p;
    logic signed [ctaf_pkg::DIFF_W-1:0]   d_reg, d_next;
    logic signed [ctaf_pkg::BLEND_W-1:0]  blend_reg, blend_next;
    logic signed [ctaf_pkg::RND_W-1:0]    rnd_reg, rnd_next;
    logic signed [ctaf_pkg::ANGLE_W-1:0]  angle_reg, angle_next, sat_val;
    logic [ctaf_pkg::ALPHA_W-1:0]         alpha_reg, alpha_next, alpha_wr;
    logic [ctaf_pkg::DT_W-1:0]            dt_reg, dt_next;
    logic signed [ctaf_pkg::MUL_A_W-1:0]  mul_a;
    logic signed [ctaf_pkg::MUL_B_W-1:0]  mul_b;
    logic signed [ctaf_pkg::DIFF_W-ctaf_pkg::D_SPLIT-1:0] d_hi;

    assign m_tilt_angle = angle_reg;

    assign xs       = ctaf_pkg::CORDIC_W'(s_accel_x) <<< 8;
    assign zs       = ctaf_pkg::CORDIC_W'(s_accel_z) <<< 8;
    assign dx       = x_reg >>> cmd.iter_idx;
    assign dz       = z_reg >>> cmd.iter_idx;
    assign step_ang = $signed(ctaf_pkg::ACC_W'(ctaf_pkg::atan_entry(
                          ctaf_pkg::TAB_IDX_W'(cmd.iter_idx))));
    assign d_hi     = d_reg[ctaf_pkg::DIFF_W-1:ctaf_pkg::D_SPLIT];

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (cmd.tilt) begin
            mul_a = ctaf_pkg::MUL_A_W'(rate_reg);
            mul_b = $signed({1'b0, dt_reg});
        end else if (cmd.mul_lo) begin
            mul_a = $signed({{(ctaf_pkg::MUL_A_W-ctaf_pkg::D_SPLIT){1'b0}},
                             d_reg[ctaf_pkg::D_SPLIT-1:0]});
            mul_b = $signed({{(ctaf_pkg::MUL_B_W-ctaf_pkg::ALPHA_W){1'b0}}, alpha_reg});
        end else if (cmd.mul_hi) begin
            mul_a = ctaf_pkg::MUL_A_W'(d_hi);
            mul_b = $signed({{(ctaf_pkg::MUL_B_W-ctaf_pkg::ALPHA_W){1'b0}}, alpha_reg});
        end
    end

    assign mul_p = ctaf_pkg::PROD_W'(mul_a) * ctaf_pkg::PROD_W'(mul_b);

    always_comb begin
        if (rnd_reg > ctaf_pkg::ANGLE_MAX) begin
            sat_val = ctaf_pkg::ANGLE_W'(ctaf_pkg::ANGLE_MAX);
        end else if (rnd_reg < ctaf_pkg::ANGLE_MIN) begin
            sat_val = ctaf_pkg::ANGLE_W'(ctaf_pkg::ANGLE_MIN);
        end else begin
            sat_val = ctaf_pkg::ANGLE_W'(rnd_reg);
        end
    end

    always_comb begin
        x_next     = x_reg;
        z_next     = z_reg;
        acc_next   = acc_reg;
        zero_next  = zero_reg;
        rate_next  = rate_reg;
        tilt_next  = tilt_reg;
        prod_next  = prod_reg;
        d_next     = d_reg;
        blend_next = blend_reg;
        rnd_next   = rnd_reg;
        angle_next = angle_reg;
        if (cmd.load) begin
            zero_next = (s_accel_x == 0) && (s_accel_z == 0);
            rate_next = s_gyro_rate;
            // fold the left half-plane onto the right
            if (s_accel_x < 0) begin
                x_next   = -xs;
                z_next   = -zs;
                acc_next = (s_accel_z >= 0) ? ctaf_pkg::ACC_HALF_TURN
                                            : -ctaf_pkg::ACC_HALF_TURN;
            end else begin
                x_next   = xs;
                z_next   = zs;
                acc_next = '0;
            end
        end
        if (cmd.iterate) begin
            if (z_reg >= 0) begin
                x_next   = x_reg + dz;
                z_next   = z_reg - dx;
                acc_next = acc_reg + step_ang;
            end else begin
                x_next   = x_reg - dz;
                z_next   = z_reg + dx;
                acc_next = acc_reg - step_ang;
            end
        end
        if (cmd.tilt) begin
            tilt_next = zero_reg ? '0 :
                ctaf_pkg::ANGLE_W'((acc_reg + ctaf_pkg::TILT_RND) >>> ctaf_pkg::UP);
            prod_next = mul_p;
        end
        if (cmd.diff) begin
            d_next = (ctaf_pkg::DIFF_W'(angle_reg) <<< ctaf_pkg::UP)
                   + ctaf_pkg::DIFF_W'(prod_reg)
                   - (ctaf_pkg::DIFF_W'(tilt_reg) <<< ctaf_pkg::UP);
        end
        if (cmd.mul_lo) begin
            prod_next = mul_p;
        end
        if (cmd.mul_hi) begin
            prod_next  = mul_p;
            blend_next = (ctaf_pkg::BLEND_W'(tilt_reg) <<< ctaf_pkg::BLEND_SH)
                       + ctaf_pkg::BLEND_W'(prod_reg);
        end
        if (cmd.sum) begin
            blend_next = blend_reg + (ctaf_pkg::BLEND_W'(prod_reg) <<< ctaf_pkg::D_SPLIT);
        end
        if (cmd.round) begin
            rnd_next = ctaf_pkg::RND_W'((blend_reg + ctaf_pkg::BLEND_RND)
                                        >>> ctaf_pkg::BLEND_SH);
        end
        if (cmd.commit) begin
            angle_next = sat_val;
        end
    end

    // clamp alpha to one on write
    assign alpha_wr = (cfg_data[ctaf_pkg::ALPHA_W-1:0] > ctaf_pkg::ALPHA_ONE)
                    ? ctaf_pkg::ALPHA_ONE : cfg_data[ctaf_pkg::ALPHA_W-1:0];

    always_comb begin
        alpha_next = alpha_reg;
        dt_next    = dt_reg;
        if (cfg_wr) begin
            case (cfg_index)
                ctaf_pkg::REG_BLEND_WEIGHT:  alpha_next = alpha_wr;
                ctaf_pkg::REG_SAMPLE_PERIOD: dt_next    = cfg_data[ctaf_pkg::DT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            angle_reg <= '0;
            alpha_reg <= ctaf_pkg::ALPHA_RESET;
            dt_reg    <= ctaf_pkg::DT_RESET;
        end else begin
            angle_reg <= angle_next;
            alpha_reg <= alpha_next;
            dt_reg    <= dt_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg     <= x_next;
        z_reg     <= z_next;
        acc_reg   <= acc_next;
        zero_reg  <= zero_next;
        rate_reg  <= rate_next;
        tilt_reg  <= tilt_next;
        prod_reg  <= prod_next;
        d_reg     <= d_next;
        blend_reg <= blend_next;
        rnd_reg   <= rnd_next;
    end

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Tilt filter testbench
// Sends accelerometer/gyro samples over the input channel. A local fixed-point
// model of the CORDIC tilt and complementary blend predicts every filtered
// angle, and each result transfer is checked in order. Stimulus covers field
// extremes, the zero vector, negative X on the axis, weights above one,
// saturation, writes to spare register indexes, and a sweep of register
// settings. Random gaps on both channels and a long output stall are included.
// ----------------------------------------------------------------------------
module testbench;
    import ctaf_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_LIMIT = 20000;
    localparam int HOLD_CYCLES = 600;
    localparam int IDLE_MAX    = 19;
    localparam int PHASE_ITEMS = 155;
    localparam int BURST_ITEMS = 80;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);

    localparam int     TAB_FRAC    = 24;
    localparam int     TILT_UP     = TAB_FRAC - ANGLE_FRACTION_BITS;
    localparam int     BLEND_SHIFT = 16 + TILT_UP;
    localparam longint HALF_TURN   = longint'(180) << TAB_FRAC;
    localparam longint ANGLE_HI    = (longint'(1) << (ANGLE_W - 1)) - 1;
    localparam longint ANGLE_LO    = -(longint'(1) << (ANGLE_W - 1));
    localparam longint WEIGHT_ONE  = longint'(ALPHA_ONE);

    localparam longint ATAN_DEG24 [0:23] = '{
        754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
        15018523, 7509720, 3754917, 1877466, 938734, 469367,
        234684, 117342, 58671, 29335, 14668, 7334,
        3667, 1833, 917, 458, 229, 115
    };

    logic                         aclk        = 1'b0;
    logic                         aresetn     = 1'b0;
    logic                         s_valid     = 1'b0;
    logic                         s_ready;
    logic signed [ACCEL_W-1:0]    s_accel_x   = '0;
    logic signed [ACCEL_W-1:0]    s_accel_z   = '0;
    logic signed [RATE_W-1:0]     s_gyro_rate = '0;
    logic                         m_valid;
    logic                         m_ready     = 1'b0;
    logic signed [ANGLE_W-1:0]    m_tilt_angle;
    logic                         cfg_valid   = 1'b0;
    logic                         cfg_ready;
    logic [CFG_IDX_W-1:0]         cfg_index   = '0;
    logic [CFG_DATA_W-1:0]        cfg_data    = '0;

    logic signed [ANGLE_W-1:0]    expected_angles [$];
    longint                       est_angle;
    logic [ALPHA_W-1:0]           weight_cfg;
    logic [DT_W-1:0]              period_cfg;
    int                           fail_count  = 0;
    int                           cycle_count = 0;
    bit                           src_idle    = 1'b1;
    bit                           sink_idle   = 1'b1;
    bit                           sink_hold   = 1'b0;

    complementary_tilt_angle_filter_top dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_accel_x    (s_accel_x),
        .s_accel_z    (s_accel_z),
        .s_gyro_rate  (s_gyro_rate),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_tilt_angle (m_tilt_angle),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic void note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("%s", msg);
    endfunction

    function automatic longint cordic_tilt_deg(input longint x_in, input longint z_in);
        longint x, z, dx, dz, acc;
        int     i;
        if (x_in == 0 && z_in == 0)
            return 0;
        x   = x_in * 256;
        z   = z_in * 256;
        acc = 0;
        if (x < 0) begin
            acc = (z >= 0) ? HALF_TURN : -HALF_TURN;
            x   = -x;
            z   = -z;
        end
        for (i = 0; i < CORDIC_STEPS && i < 24; i++) begin
            dx = x >>> i;
            dz = z >>> i;
            if (z >= 0) begin
                x   += dz;
                z   -= dx;
                acc += ATAN_DEG24[i];
            end else begin
                x   -= dz;
                z   += dx;
                acc -= ATAN_DEG24[i];
            end
        end
        return (acc + (longint'(1) << (TILT_UP - 1))) >>> TILT_UP;
    endfunction

    function automatic logic signed [ANGLE_W-1:0] predict_angle(
        input logic signed [ACCEL_W-1:0] ax,
        input logic signed [ACCEL_W-1:0] az,
        input logic signed [RATE_W-1:0]  rate
    );
        longint weight, tilt, gyro_path, blend, nxt;
        weight    = (weight_cfg > ALPHA_ONE) ? WEIGHT_ONE : longint'(weight_cfg);
        tilt      = cordic_tilt_deg(longint'(ax), longint'(az));
        gyro_path = est_angle * (longint'(1) << TILT_UP) + longint'(rate) * longint'(period_cfg);
        blend     = weight * gyro_path + (WEIGHT_ONE - weight) * (tilt << TILT_UP);
        nxt       = (blend + (longint'(1) << (BLEND_SHIFT - 1))) >>> BLEND_SHIFT;
        if (nxt > ANGLE_HI)
            nxt = ANGLE_HI;
        if (nxt < ANGLE_LO)
            nxt = ANGLE_LO;
        est_angle = nxt;
        return ANGLE_W'(nxt);
    endfunction

    always @(posedge aclk) begin
        logic signed [ANGLE_W-1:0] want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_angles.size() == 0) begin
                note_failure($sformatf("unexpected result transfer: angle %0d", m_tilt_angle));
            end else begin
                want = expected_angles.pop_front();
                if (m_tilt_angle !== want)
                    note_failure($sformatf("angle mismatch: expected %0d, got %0d",
                                           want, m_tilt_angle));
            end
        end
    end

    initial begin : result_sink
        int stall;
        forever begin
            stall = sink_idle ? $urandom_range(0, IDLE_MAX) : 0;
            if (stall > 0 || sink_hold) begin
                m_ready <= 1'b0;
                while (stall > 0 || sink_hold) begin
                    @(posedge aclk);
                    if (stall > 0)
                        stall--;
                end
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    task automatic send_sample(
        input logic signed [ACCEL_W-1:0] ax,
        input logic signed [ACCEL_W-1:0] az,
        input logic signed [RATE_W-1:0]  rate
    );
        int gap;
        gap = src_idle ? $urandom_range(0, IDLE_MAX) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_accel_x   <= ax;
        s_accel_z   <= az;
        s_gyro_rate <= rate;
        do @(posedge aclk); while (!s_ready);
        expected_angles.push_back(predict_angle(ax, az, rate));
    endtask

    task automatic end_burst();
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_random_sample();
        logic signed [ACCEL_W-1:0] ax, az;
        logic signed [RATE_W-1:0]  rate;
        ax   = ACCEL_W'($urandom);
        az   = ACCEL_W'($urandom);
        rate = RATE_W'(int'($urandom_range(0, 8191)) - 4096);
        case ($urandom_range(0, 3))
            0: rate = RATE_W'($urandom);
            1: begin
                ax = ACCEL_W'(int'($urandom_range(0, 64)) - 32);
                az = ACCEL_W'(int'($urandom_range(0, 64)) - 32);
            end
            2: begin
                if ($urandom_range(0, 1))
                    az = '0;
                else
                    ax = '0;
            end
            default: ;
        endcase
        send_sample(ax, az, rate);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_BLEND_WEIGHT:  weight_cfg = data[ALPHA_W-1:0];
            REG_SAMPLE_PERIOD: period_cfg = data[DT_W-1:0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic wait_idle();
        while (expected_angles.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic apply_reset();
        est_angle  = 0;
        weight_cfg = ALPHA_RESET;
        period_cfg = DT_RESET;
        aresetn <= 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
    endtask

    task automatic test_field_extremes();
        send_sample(16'sh7FFF, 16'sh0000, 24'sh000000);
        send_sample(16'sh0000, 16'sh7FFF, 24'sh7FFFFF);
        send_sample(16'sh0000, 16'sh8000, 24'sh800000);
        send_sample(16'sh7FFF, 16'sh7FFF, 24'sh000001);
        send_sample(16'sh8000, 16'sh8000, 24'shFFFFFF);
        send_sample(16'sh8000, 16'sh7FFF, 24'sh000000);
        send_sample(16'sh7FFF, 16'sh8000, 24'sh000100);
        send_sample(16'sh0001, 16'shFFFF, 24'sh00FF00);
        end_burst();
    endtask

    task automatic test_zero_and_axis();
        send_sample(16'sh0000, 16'sh0000, 24'sh000000);
        send_sample(16'sh0000, 16'sh0000, 24'sh001388);
        send_sample(16'shFFFF, 16'sh0000, 24'sh000000);
        send_sample(16'sh8000, 16'sh0000, -24'sd100);
        send_sample(16'sh0001, 16'sh0000, 24'sh000000);
        end_burst();
    endtask

    task automatic test_weight_above_one();
        wait_idle();
        write_reg(REG_BLEND_WEIGHT, 20'hFFFFF);
        send_sample(16'sh1234, 16'sh0F00, 24'sh004000);
        send_sample(16'shC000, 16'sh2000, -24'sd3000);
        send_sample(16'sh0400, 16'shF000, 24'sh000000);
        end_burst();
    endtask

    task automatic test_saturation();
        wait_idle();
        write_reg(REG_BLEND_WEIGHT, CFG_DATA_W'(ALPHA_ONE));
        write_reg(REG_SAMPLE_PERIOD, 20'hFFFFF);
        send_sample(16'sh0064, 16'sh0064, 24'sh7FFFFF);
        send_sample(16'sh0064, 16'sh0064, 24'sh7FFFFF);
        send_sample(-16'sd100, 16'sh0032, 24'sh800000);
        send_sample(-16'sd100, 16'sh0032, 24'sh800000);
        end_burst();
    endtask

    task automatic test_spare_indexes();
        wait_idle();
        write_reg(REG_BLEND_WEIGHT, 20'd32768);
        write_reg(REG_SAMPLE_PERIOD, 20'd6554);
        write_reg(REG_SPARE_A, 20'h00000);
        write_reg(REG_SPARE_B, 20'hFFFFF);
        send_sample(16'sh2000, 16'sh2000, 24'sh012345);
        send_sample(16'shE000, 16'sh1000, -24'sd70000);
        end_burst();
    endtask

    task automatic run_phase(input int weight, input int period, input bit [1:0] idling);
        wait_idle();
        write_reg(REG_BLEND_WEIGHT, {(CFG_DATA_W-ALPHA_W)'($urandom), ALPHA_W'(weight)});
        write_reg(REG_SAMPLE_PERIOD, CFG_DATA_W'(period));
        src_idle  = idling[0];
        sink_idle <= idling[1];
        repeat (PHASE_ITEMS) send_random_sample();
        end_burst();
    endtask

    task automatic test_setting_sweep();
        run_phase(int'(ALPHA_RESET), int'(DT_RESET), 2'b11);
        run_phase(0, 6554, 2'b01);
        run_phase(65536, 6554, 2'b10);
        run_phase(65535, 0, 2'b00);
        run_phase(1, 1, 2'b11);
        run_phase(32768, 1048575, 2'b11);
        run_phase(100000, 3000, 2'b01);
        run_phase(6554, 65536, 2'b10);
        run_phase(58982, 655, 2'b11);
        run_phase(131071, 20, 2'b11);
    endtask

    task automatic test_output_stall();
        src_idle = 1'b0;
        fork
            begin
                sink_hold <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge aclk);
                sink_hold <= 1'b0;
            end
        join_none
        repeat (BURST_ITEMS) send_random_sample();
        end_burst();
        src_idle = 1'b1;
    endtask

    initial begin
        int waited;
        apply_reset();
        test_field_extremes();
        test_zero_and_axis();
        test_weight_above_one();
        test_saturation();
        test_spare_indexes();
        test_setting_sweep();
        test_output_stall();
        waited = 0;
        while (expected_angles.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (30) @(posedge aclk);
        if (expected_angles.size() != 0)
            note_failure($sformatf("%0d results never arrived", expected_angles.size()));
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
